FILE: rtl/gle_pkg.sv
// ----------------------------------------------------------------------------
// GIF LZW encoder package
// Shared widths, special codes and controller/datapath command structs.
// ----------------------------------------------------------------------------
package gle_pkg;

   localparam int CHAR_W      = 8;
   localparam int CODE_W      = 12;
   localparam int LINK_W      = 13;
   localparam int CWIDTH_W    = 4;
   localparam int ACC_W       = 32;
   localparam int CNT_W       = 6;

   localparam logic [CODE_W-1:0] CODE_CLEAR = 12'd256;
   localparam logic [CODE_W-1:0] CODE_END   = 12'd257;
   localparam logic [LINK_W-1:0] FIRST_FREE = 13'd258;
   localparam logic [LINK_W-1:0] FIRST_BUMP = 13'd512;
   localparam logic [CWIDTH_W-1:0] START_WIDTH = 4'd9;
   localparam logic [CWIDTH_W-1:0] MAX_WIDTH   = 4'd12;

   // Which code the packer appends
   typedef enum logic [1:0] {
      PUT_PREFIX,
      PUT_END
   } put_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        take_item;     // latch pixel and last flag
      logic        set_first;     // prefix <= pixel, have_prefix <= 1
      logic        head_rd;       // read bucket head
      logic        head_use;      // head read data valid: start walk
      logic        dict_rd;       // read dictionary at walk pointer
      logic        dict_use;      // dictionary data valid: compare
      logic        hit_take;      // prefix <= hit entry
      logic        miss_put;      // prefix <= pixel after a miss
      logic        add_entry;     // write new entry and bucket head
      logic        put_code;      // pack a code
      put_sel_type put_sel;
      logic        emit_byte;     // take one byte from accumulator
      logic        flush_byte;    // take partial byte
      logic        clear_step;    // clear one bucket head
      logic        clear_start;   // reset scalar state, start clearing pass
   } gle_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic have_prefix;
      logic last;
      logic match;        // compared entry matches
      logic chain_end;    // walk pointer is zero or out of range
      logic byte_ready;   // eight or more bits pending
      logic bits_left;    // some bits pending
      logic clear_done;   // clearing pass finished
   } gle_sts_type;

endpackage

FILE: rtl/gle_stream_if.sv
// ----------------------------------------------------------------------------
// GIF LZW stream interfaces
// Valid/ready channels for pixel items and byte items.
// ----------------------------------------------------------------------------
interface gle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_index;
   logic       end_of_image;
   modport source (output valid, pixel_index, end_of_image, input ready);
   modport sink   (input valid, pixel_index, end_of_image, output ready);
endinterface

interface gle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       stream_end;
   modport source (output valid, out_byte, run_last, stream_end, input ready);
   modport sink   (input valid, out_byte, run_last, stream_end, output ready);
endinterface

FILE: rtl/gle_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/gle_datapath.sv
// ----------------------------------------------------------------------------
// GIF LZW encoder datapath
// Dictionary and bucket memories, prefix and code state, bit packer.
// ----------------------------------------------------------------------------
module gle_datapath #(
   parameter int DICT_ENTRIES = 4096,
   parameter int HASH_BUCKETS = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gle_pkg::gle_cmd_type       cmd,
   output gle_pkg::gle_sts_type       sts,
   input  logic [gle_pkg::CHAR_W-1:0] pixel,
   input  logic                       last_in,
   output logic [7:0]                 byte_out
);
   localparam int DA_W = $clog2(DICT_ENTRIES);
   localparam int BA_W = $clog2(HASH_BUCKETS);
   localparam int ENT_W = gle_pkg::CODE_W + gle_pkg::CHAR_W + gle_pkg::LINK_W;
   localparam logic [gle_pkg::LINK_W:0] DICT_LIM = (gle_pkg::LINK_W+1)'(DICT_ENTRIES);

   logic [gle_pkg::CHAR_W-1:0]   char_ff;
   logic                         last_ff;
   logic [gle_pkg::CODE_W-1:0]   prefix_ff;
   logic                         have_ff;
   logic [gle_pkg::LINK_W-1:0]   next_ff;
   logic [gle_pkg::CWIDTH_W-1:0] width_ff;
   logic [gle_pkg::LINK_W:0]     bump_ff;
   logic [gle_pkg::ACC_W-1:0]    acc_ff;
   logic [gle_pkg::CNT_W-1:0]    nbits_ff;
   logic [gle_pkg::LINK_W-1:0]   pos_ff;
   logic [gle_pkg::LINK_W-1:0]   head_ff;
   logic [BA_W-1:0]              clr_ff;
   logic                         clearing_ff;

   logic [BA_W-1:0]              bucket;
   logic [gle_pkg::LINK_W-1:0]   head_rd;
   logic [ENT_W-1:0]             ent_rd;
   logic [gle_pkg::CODE_W-1:0]   ent_prefix;
   logic [gle_pkg::CHAR_W-1:0]   ent_char;
   logic [gle_pkg::LINK_W-1:0]   ent_link;
   logic [gle_pkg::CODE_W-1:0]   code;
   logic [gle_pkg::ACC_W-1:0]    shifted;
   logic                         can_add;

   // Bucket of (prefix, char)
   assign bucket = BA_W'(({1'b0, prefix_ff} + {5'd0, char_ff}));
   assign can_add = ({1'b0, next_ff} < DICT_LIM);

   gle_ram #(.WIDTH(gle_pkg::LINK_W), .DEPTH(HASH_BUCKETS)) u_head (
      .clock  (clock),
      .wr_en  (clearing_ff || (cmd.add_entry && can_add)),
      .wr_addr(clearing_ff ? clr_ff : bucket),
      .wr_data(clearing_ff ? '0 : next_ff),
      .rd_en  (cmd.head_rd),
      .rd_addr(bucket),
      .rd_data(head_rd)
   );

   gle_ram #(.WIDTH(ENT_W), .DEPTH(DICT_ENTRIES)) u_dict (
      .clock  (clock),
      .wr_en  (cmd.add_entry && can_add),
      .wr_addr(DA_W'(next_ff)),
      .wr_data({prefix_ff, char_ff, head_ff}),
      .rd_en  (cmd.dict_rd),
      .rd_addr(DA_W'(pos_ff)),
      .rd_data(ent_rd)
   );

   assign {ent_prefix, ent_char, ent_link} = ent_rd;

   assign code = (cmd.put_sel == gle_pkg::PUT_END) ? gle_pkg::CODE_END : prefix_ff;
   assign shifted = gle_pkg::ACC_W'({20'd0, code} << nbits_ff[4:0]);

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         char_ff <= pixel;
         last_ff <= last_in;
      end
      if (cmd.head_use) begin
         pos_ff  <= head_rd;
         head_ff <= head_rd;
      end else if (cmd.dict_use) pos_ff <= ent_link;
      if (reset || cmd.clear_start) begin
         prefix_ff   <= '0;
         have_ff     <= 1'b0;
         next_ff     <= gle_pkg::FIRST_FREE;
         width_ff    <= gle_pkg::START_WIDTH;
         bump_ff     <= {1'b0, gle_pkg::FIRST_BUMP};
         acc_ff      <= gle_pkg::ACC_W'(gle_pkg::CODE_CLEAR);
         nbits_ff    <= gle_pkg::CNT_W'(9);
         clr_ff      <= '0;
         clearing_ff <= 1'b1;
      end else begin
         // Clearing pass over bucket heads
         if (clearing_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == BA_W'(HASH_BUCKETS-1)) clearing_ff <= 1'b0;
         end
         // Prefix register
         if (cmd.set_first) begin
            prefix_ff <= char_ff;
            have_ff   <= 1'b1;
         end else if (cmd.hit_take) prefix_ff <= gle_pkg::CODE_W'(pos_ff);
         else if (cmd.miss_put) prefix_ff <= char_ff;
         // Packer: append code, drop one byte or take the partial byte
         if (cmd.put_code) begin
            acc_ff   <= acc_ff | shifted;
            nbits_ff <= nbits_ff + gle_pkg::CNT_W'(width_ff);
         end else if (cmd.emit_byte) begin
            acc_ff   <= acc_ff >> 8;
            nbits_ff <= nbits_ff - gle_pkg::CNT_W'(8);
         end else if (cmd.flush_byte) begin
            acc_ff   <= '0;
            nbits_ff <= '0;
         end
         if (cmd.add_entry && can_add) begin
            next_ff <= next_ff + 1'b1;
            if ({1'b0, next_ff} == bump_ff && width_ff < gle_pkg::MAX_WIDTH) begin
               width_ff <= width_ff + 1'b1;
               bump_ff  <= bump_ff << 1;
            end
         end
      end
   end

   assign byte_out = acc_ff[7:0];

   always_comb begin
      sts.have_prefix = have_ff;
      sts.last        = last_ff;
      sts.match       = (ent_prefix == prefix_ff) && (ent_char == char_ff);
      sts.chain_end   = (pos_ff == '0) || ({1'b0, pos_ff} >= DICT_LIM);
      sts.byte_ready  = (nbits_ff >= gle_pkg::CNT_W'(8));
      sts.bits_left   = (nbits_ff != '0);
      sts.clear_done  = !clearing_ff;
   end

endmodule

FILE: rtl/gle_control.sv
// ----------------------------------------------------------------------------
// GIF LZW encoder controller
// Sequences chain walk, entry add, code packing and byte output per item.
// ----------------------------------------------------------------------------
module gle_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 run_last,
   output logic                 stream_end,
   output logic                 load_byte,
   output gle_pkg::gle_cmd_type cmd,
   input  gle_pkg::gle_sts_type sts
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECIDE, S_HEAD, S_HEADUSE, S_DICT, S_CMP,
      S_ADD, S_EMIT, S_ENDP, S_ENDE, S_FLUSH, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      out_full_ff;
   logic      after_ff, after_in;   // where S_EMIT returns
   logic      pend_ff;              // a byte held in output register is not yet known last
   logic      pend_last_ff;
   logic      out_last_ff, out_end_ff;
   logic      can_load;
   logic      want_load;            // a byte is waiting to enter the output register
   logic      fin_in;               // item processing finished, mark held byte last

   // Output register frees when empty or when its byte is taken
   assign rsp_valid = out_full_ff && !pend_ff;
   assign can_load  = !out_full_ff || (rsp_valid && rsp_ready);

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      after_in  = after_ff;
      fin_in    = 1'b0;
      req_ready = 1'b0;
      load_byte = 1'b0;
      want_load = 1'b0;
      unique case (state_ff)
         S_CLEAR: if (sts.clear_done) state_in = S_IDLE;
         S_IDLE: begin
            req_ready = !pend_ff;
            if (req_valid && !pend_ff) begin
               cmd.take_item = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!sts.have_prefix) begin
               cmd.set_first = 1'b1;
               state_in = sts.last ? S_ENDP : S_DONE;
            end else begin
               cmd.head_rd = 1'b1;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.head_use = 1'b1;
            state_in = S_HEADUSE;
         end
         S_HEADUSE: begin
            if (sts.chain_end) state_in = S_ADD;
            else begin
               cmd.dict_rd = 1'b1;
               state_in = S_DICT;
            end
         end
         S_DICT: state_in = S_CMP;
         S_CMP: begin
            if (sts.match) begin
               cmd.hit_take = 1'b1;
               state_in = sts.last ? S_ENDP : S_DONE;
            end else begin
               cmd.dict_use = 1'b1;
               state_in = S_HEADUSE;
            end
         end
         S_ADD: begin
            cmd.put_code  = 1'b1;
            cmd.put_sel   = gle_pkg::PUT_PREFIX;
            cmd.add_entry = 1'b1;
            cmd.miss_put  = 1'b1;
            after_in = 1'b0;
            state_in = S_EMIT;
         end
         S_ENDP: begin
            cmd.put_code = 1'b1;
            cmd.put_sel  = gle_pkg::PUT_PREFIX;
            after_in = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.byte_ready) begin
               want_load = 1'b1;
               if (can_load) begin
                  cmd.emit_byte = 1'b1;
                  load_byte = 1'b1;
               end
            end else if (after_ff) state_in = S_ENDE;
            else state_in = sts.last ? S_ENDP : S_DONE;
            if (!sts.byte_ready && !after_ff && sts.last) begin
               after_in = 1'b1;
            end
         end
         S_ENDE: begin
            cmd.put_code = 1'b1;
            cmd.put_sel  = gle_pkg::PUT_END;
            after_in = 1'b0;
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            if (sts.byte_ready) begin
               want_load = 1'b1;
               if (can_load) begin
                  cmd.emit_byte = 1'b1;
                  load_byte = 1'b1;
               end
            end else if (sts.bits_left) begin
               want_load = 1'b1;
               if (can_load) begin
                  cmd.flush_byte = 1'b1;
                  load_byte = 1'b1;
                  state_in = S_DONE;
               end
            end else state_in = S_DONE;
         end
         S_DONE: begin
            fin_in = 1'b1;
            if (sts.last) cmd.clear_start = 1'b1;
            state_in = sts.last ? S_CLEAR : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // S_EMIT after prefix code of a miss falls to S_ENDP when last; the
   // after flag is set then so the end code follows.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         after_ff    <= 1'b0;
         out_full_ff <= 1'b0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         if (load_byte) begin
            out_full_ff <= 1'b1;
            pend_ff     <= 1'b1;
         end else begin
            if (rsp_valid && rsp_ready) out_full_ff <= 1'b0;
            // Held byte shows once the next byte or the item end is known
            if ((want_load || fin_in) && pend_ff) pend_ff <= 1'b0;
         end
      end
      if (load_byte) begin
         out_last_ff  <= 1'b0;
         out_end_ff   <= 1'b0;
         pend_last_ff <= sts.last;
      end else if (fin_in && pend_ff) begin
         out_last_ff <= 1'b1;
         out_end_ff  <= pend_last_ff;
      end
   end

   assign run_last   = out_last_ff;
   assign stream_end = out_end_ff;
endmodule

FILE: rtl/gif_lzw_encoder.sv
// ----------------------------------------------------------------------------
// GIF LZW encoder
// Packs 8-bit palette indices into the GIF LZW byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one pixel item (pixel_index, end_of_image) per handshake.
//   rsp carries packed code bytes, LSB first; run_last marks the last byte
//   an item causes, stream_end the final byte of the image.
//   Items are handled one at a time. A pixel that opens an image only
//   sets the prefix; any other reads its bucket head and walks the chain,
//   and when no string matches, packs the prefix code, adds an entry and
//   emits the whole bytes. The end of an image packs the prefix and end
//   codes and flushes the partial byte. The walk is set by the
//   registered-read dictionary memory, one entry per compare.
//   A byte sits in the output register until the next byte or the end of
//   its item is known, so the last byte of an item can be flagged.
//   After reset and after every image end a clearing pass over all
//   HASH_BUCKETS bucket heads empties them; no item is taken.
//   A stalled receiver holds the byte and stops the sequencer.
// ----------------------------------------------------------------------------
module gif_lzw_encoder #(
   parameter int DICT_ENTRIES = 4096,
   parameter int HASH_BUCKETS = 256
) (
   input logic        clock,
   input logic        reset,
   gle_req_if.sink    req,
   gle_rsp_if.source  rsp
);
   gle_pkg::gle_cmd_type cmd;
   gle_pkg::gle_sts_type sts;
   logic [7:0] byte_dp;
   logic [7:0] out_byte_ff;
   logic       load_byte;

   gle_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .run_last  (rsp.run_last),
      .stream_end(rsp.stream_end),
      .load_byte (load_byte),
      .cmd       (cmd),
      .sts       (sts)
   );

   gle_datapath #(.DICT_ENTRIES(DICT_ENTRIES), .HASH_BUCKETS(HASH_BUCKETS)) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .sts     (sts),
      .pixel   (req.pixel_index),
      .last_in (req.end_of_image),
      .byte_out(byte_dp)
   );

   // Output byte register
   always_ff @(posedge clock) begin
      if (load_byte) out_byte_ff <= byte_dp;
   end
   assign rsp.out_byte = out_byte_ff;

   // Assertions
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready) else $error("accept while busy");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.stream_end) |-> rsp.run_last) else $error("end without last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("byte dropped");
endmodule
